// ===== rtl/sgse_pkg.sv =====
package sgse_pkg;

    // Vertex states as stored in the state banks.
    localparam logic [1:0] ST_SUSC = 2'd0;
    localparam logic [1:0] ST_INF  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INFECT_PROB = 2'd0;
    localparam logic [1:0] CFG_REMOVE_PROB = 2'd1;
    localparam logic [1:0] CFG_MAX_SWEEPS  = 2'd2;
    localparam logic [1:0] CFG_QUIET_LIMIT = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] MAX_SWEEPS_RST  = 16'd1024;
    localparam logic [15:0] QUIET_LIMIT_RST = 16'd1;

    // Saturation limits.
    localparam logic [23:0] SUM_MAX    = 24'hFF_FFFF;
    localparam logic [15:0] QUIET_MAX  = 16'hFFFF;
    localparam logic [16:0] SWEEPS_MAX = 17'h1_FFFF;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // A classified input transaction as it travels through the queue.
    typedef struct packed {
        logic        is_load;
        logic [9:0]  vertex;
        logic [9:0]  neighbour;
        logic [15:0] weight;
        logic        use_edge;
        logic        complete;
        logic        sweep_end;
        logic [15:0] random_draw;
        logic [1:0]  init_state;
    } item_t;

    // Configuration register values.
    typedef struct packed {
        logic [15:0] infect_prob;
        logic [15:0] remove_prob;
        logic [15:0] max_sweeps;
        logic [15:0] quiet_limit;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [9:0] out_vertex;
        logic [1:0] new_state;
        logic       sweep_end;
        logic       sweep_changed;
        logic       finished;
    } result_t;

endpackage

// ===== rtl/sgse_ram.sv =====
module sgse_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

// ===== rtl/sgse_front.sv =====
module sgse_front
    import sgse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [9:0]  vertex,
    input  logic [9:0]  neighbour,
    input  logic [15:0] weight,
    input  logic        no_edge,
    input  logic        last_of_vertex,
    input  logic        last_of_sweep,
    input  logic [15:0] random_draw,
    input  logic [1:0]  init_state,
    output logic        head_valid,
    output item_t       head,
    input  logic        pop
);

    item_t                 queue_reg [QUEUE_DEPTH];
    item_t                 in_item;
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  push;

    // Classify the incoming transaction.
    always_comb begin
        in_item.is_load     = (command == CMD_LOAD);
        in_item.vertex      = vertex;
        in_item.neighbour   = neighbour;
        in_item.weight      = weight;
        in_item.use_edge    = !no_edge;
        in_item.complete    = last_of_vertex | last_of_sweep;
        in_item.sweep_end   = last_of_sweep;
        in_item.random_draw = random_draw;
        // State code three loads as removed.
        in_item.init_state  = (init_state == 2'd3) ? ST_REM : init_state;
    end

    assign in_ready   = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/sgse_back.sv =====
module sgse_back
    import sgse_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    head_valid,
    input  item_t   head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int AW = $clog2(MAX_NODES);

    // Pipeline control.
    logic adv, hazard, issue, load_we, d_we;
    logic a_vert_ok, a_nb_ok;
    logic [AW-1:0] a_vaddr, a_naddr, d_addr;
    logic a_bank_reg, a_bank_next;

    // Bank memories.
    logic          we_a, we_b;
    logic [AW-1:0] waddr_a, waddr_b;
    logic [1:0]    wdata_a, wdata_b;
    logic [1:0]    rd_a0, rd_a1, rd_b0, rd_b1;

    // Stage B: read data returns, contact sum accumulates.
    logic        b_valid_reg, b_complete_reg, b_sweep_end_reg, b_use_edge_reg;
    logic        b_vert_ok_reg, b_bank_reg;
    logic [15:0] b_weight_reg, b_rnd_reg;
    logic [9:0]  b_vertex_reg;
    logic [23:0] sum_reg, sum_next, sum_add;
    logic [24:0] sum_wide;
    logic [1:0]  b_nb_state, b_cur;

    // Stage C: infection product.
    logic        c_valid_reg, c_sweep_end_reg, c_vert_ok_reg, c_bank_reg;
    logic [23:0] c_sum_reg;
    logic [1:0]  c_cur_reg;
    logic [15:0] c_rnd_reg;
    logic [9:0]  c_vertex_reg;

    // Stage D: decision, bank write, sweep bookkeeping.
    logic        d_valid_reg, d_sweep_end_reg, d_vert_ok_reg, d_bank_reg;
    logic        d_remove_hit_reg;
    logic [39:0] d_product_reg;
    logic [1:0]  d_cur_reg, d_nxt;
    logic [15:0] d_rnd_reg;
    logic [9:0]  d_vertex_reg;
    logic        d_any, d_fin, d_changed;

    // Sweep state.
    logic        any_change_reg, any_change_next;
    logic [15:0] quiet_reg, quiet_next;
    logic [16:0] sweeps_reg, sweeps_next;

    // Output register.
    logic    out_valid_reg;
    result_t out_result_reg, out_result_next;

    // The whole back pipeline moves together when the output can take data.
    assign adv = !out_valid_reg || out_ready;

    // Hold issue while a sweep end is still in flight, so that the next sweep
    // reads and loads only after every write of this sweep has landed.
    assign hazard = (b_valid_reg && b_sweep_end_reg) || (c_valid_reg && c_sweep_end_reg)
                 || (d_valid_reg && d_sweep_end_reg);
    assign issue  = adv && head_valid && !hazard;
    assign pop    = issue;

    // Stage A: address decode and range checks.
    assign a_vert_ok = ({22'd0, head.vertex} < 32'(MAX_NODES));
    assign a_nb_ok   = ({22'd0, head.neighbour} < 32'(MAX_NODES));
    assign a_vaddr   = AW'(head.vertex);
    assign a_naddr   = AW'(head.neighbour);
    assign load_we   = issue && head.is_load && a_vert_ok;
    assign a_bank_next = (issue && !head.is_load && head.sweep_end) ? !a_bank_reg : a_bank_reg;

    // Bank write steering: loads go to the bank being read, updates to the other bank.
    assign d_addr = AW'(d_vertex_reg);
    assign d_we   = adv && d_valid_reg && d_vert_ok_reg;
    always_comb begin
        we_a    = (d_we && d_bank_reg) || (load_we && !a_bank_reg);
        we_b    = (d_we && !d_bank_reg) || (load_we && a_bank_reg);
        waddr_a = (d_we && d_bank_reg) ? d_addr : a_vaddr;
        wdata_a = (d_we && d_bank_reg) ? d_nxt : head.init_state;
        waddr_b = (d_we && !d_bank_reg) ? d_addr : a_vaddr;
        wdata_b = (d_we && !d_bank_reg) ? d_nxt : head.init_state;
    end

    sgse_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_bank_a (
        .aclk   (aclk),
        .we     (we_a),
        .waddr  (waddr_a),
        .wdata  (wdata_a),
        .re     (adv),
        .raddr0 (a_naddr),
        .raddr1 (a_vaddr),
        .rdata0 (rd_a0),
        .rdata1 (rd_a1)
    );

    sgse_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_bank_b (
        .aclk   (aclk),
        .we     (we_b),
        .waddr  (waddr_b),
        .wdata  (wdata_b),
        .re     (adv),
        .raddr0 (a_naddr),
        .raddr1 (a_vaddr),
        .rdata0 (rd_b0),
        .rdata1 (rd_b1)
    );

    // Stage B: saturating contact sum and current vertex state.
    always_comb begin
        b_nb_state = b_bank_reg ? rd_b0 : rd_a0;
        b_cur      = b_vert_ok_reg ? (b_bank_reg ? rd_b1 : rd_a1) : ST_SUSC;
        sum_wide   = {1'b0, sum_reg};
        if (b_use_edge_reg && (b_nb_state == ST_INF)) begin
            sum_wide = {1'b0, sum_reg} + {9'd0, b_weight_reg};
        end
        sum_add  = sum_wide[24] ? SUM_MAX : sum_wide[23:0];
        sum_next = sum_reg;
        if (adv && b_valid_reg) begin
            sum_next = b_complete_reg ? '0 : sum_add;
        end
    end

    // Stage D: new state and sweep bookkeeping.
    always_comb begin
        d_nxt = d_cur_reg;
        if (d_cur_reg == ST_SUSC) begin
            if ({16'd0, d_rnd_reg, 8'd0} < d_product_reg) begin
                d_nxt = ST_INF;
            end
        end else if (d_cur_reg == ST_INF) begin
            if (d_remove_hit_reg) begin
                d_nxt = ST_REM;
            end
        end
        d_any = any_change_reg || (d_nxt != d_cur_reg);

        any_change_next = any_change_reg;
        quiet_next      = quiet_reg;
        sweeps_next     = sweeps_reg;
        d_changed       = 1'b0;
        d_fin           = 1'b0;
        if (adv && d_valid_reg) begin
            any_change_next = d_any;
            if (d_sweep_end_reg) begin
                d_changed = d_any;
                if (d_any) begin
                    quiet_next = '0;
                end else if (quiet_reg != QUIET_MAX) begin
                    quiet_next = quiet_reg + 1'b1;
                end
                if (sweeps_reg != SWEEPS_MAX) begin
                    sweeps_next = sweeps_reg + 1'b1;
                end
                d_fin = (sweeps_next > {1'b0, cfg.max_sweeps})
                     || (quiet_next >= cfg.quiet_limit);
                any_change_next = 1'b0;
            end
        end

        out_result_next.out_vertex    = d_vertex_reg;
        out_result_next.new_state     = d_nxt;
        out_result_next.sweep_end     = d_sweep_end_reg;
        out_result_next.sweep_changed = d_changed;
        out_result_next.finished      = d_fin;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_bank_reg     <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_reg        <= '0;
            any_change_reg <= 1'b0;
            quiet_reg      <= '0;
            sweeps_reg     <= '0;
        end else begin
            a_bank_reg     <= a_bank_next;
            sum_reg        <= sum_next;
            any_change_reg <= any_change_next;
            quiet_reg      <= quiet_next;
            sweeps_reg     <= sweeps_next;
            if (adv) begin
                b_valid_reg   <= issue && !head.is_load;
                c_valid_reg   <= b_valid_reg && b_complete_reg;
                d_valid_reg   <= c_valid_reg;
                out_valid_reg <= d_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            b_weight_reg     <= head.weight;
            b_use_edge_reg   <= head.use_edge && a_nb_ok;
            b_complete_reg   <= head.complete;
            b_sweep_end_reg  <= head.sweep_end;
            b_vertex_reg     <= head.vertex;
            b_vert_ok_reg    <= a_vert_ok;
            b_rnd_reg        <= head.random_draw;
            b_bank_reg       <= a_bank_reg;

            c_sum_reg        <= sum_add;
            c_cur_reg        <= b_cur;
            c_rnd_reg        <= b_rnd_reg;
            c_vertex_reg     <= b_vertex_reg;
            c_vert_ok_reg    <= b_vert_ok_reg;
            c_bank_reg       <= b_bank_reg;
            c_sweep_end_reg  <= b_sweep_end_reg;

            d_product_reg    <= 40'(c_sum_reg) * 40'(cfg.infect_prob);
            d_remove_hit_reg <= (c_rnd_reg < cfg.remove_prob);
            d_cur_reg        <= c_cur_reg;
            d_rnd_reg        <= c_rnd_reg;
            d_vertex_reg     <= c_vertex_reg;
            d_vert_ok_reg    <= c_vert_ok_reg;
            d_bank_reg       <= c_bank_reg;
            d_sweep_end_reg  <= c_sweep_end_reg;

            out_result_reg   <= out_result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ===== rtl/sir_graph_sweep_engine.sv =====
// Channel   Direction  Transfer                 Payload
// s_axis    in         s_axis_tvalid & tready   loads and neighbour entries
// m_axis    out        m_axis_tvalid & tready   one result per completed vertex
// cfg       in         cfg_we                   register index and 16-bit value
//
// The input accepts a transaction whenever the queue has room; after the last neighbour
// entry of a vertex, its result passes the queue, stages B, C and D and the output register.
// After a sweep-end entry, issue pauses while it is in stage B, C or D so that the bank
// writes of the sweep land before the next sweep reads the swapped bank.
// Synchronous active-low reset clears control state; the state banks are undefined
// until loaded. A stalled output freezes the back pipeline while the queue still fills.
module sir_graph_sweep_engine
    import sgse_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] vertex, [19:10] neighbour, [35:20] weight, [36] last_of_vertex,
    // [52:37] random_draw, [54:53] init_state, [55] zero
    input  logic [55:0] s_axis_tdata,
    // [0] command, [1] no_edge
    input  logic [1:0]  s_axis_tuser,
    // last_of_sweep
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [9:0] out_vertex, [11:10] new_state, [12] sweep_changed, [13] finished,
    // [15:14] zero
    output logic [15:0] m_axis_tdata,
    // sweep_end
    output logic        m_axis_tlast,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    item_t   head;
    logic    head_valid, pop;
    logic    out_valid;
    result_t out_result;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_INFECT_PROB: cfg_next.infect_prob = cfg_data;
                CFG_REMOVE_PROB: cfg_next.remove_prob = cfg_data;
                CFG_MAX_SWEEPS:  cfg_next.max_sweeps  = cfg_data;
                CFG_QUIET_LIMIT: cfg_next.quiet_limit = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.infect_prob <= '0;
            cfg_reg.remove_prob <= '0;
            cfg_reg.max_sweeps  <= MAX_SWEEPS_RST;
            cfg_reg.quiet_limit <= QUIET_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept, classify and queue transactions.
    sgse_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .command        (s_axis_tuser[0]),
        .vertex         (s_axis_tdata[9:0]),
        .neighbour      (s_axis_tdata[19:10]),
        .weight         (s_axis_tdata[35:20]),
        .no_edge        (s_axis_tuser[1]),
        .last_of_vertex (s_axis_tdata[36]),
        .last_of_sweep  (s_axis_tlast),
        .random_draw    (s_axis_tdata[52:37]),
        .init_state     (s_axis_tdata[54:53]),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop)
    );

    // Back: state banks, contact sums and state updates.
    sgse_back #(.MAX_NODES(MAX_NODES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    // Result packing.
    assign m_axis_tvalid = out_valid;
    assign m_axis_tlast  = out_result.sweep_end;
    assign m_axis_tdata  = {2'b00, out_result.finished, out_result.sweep_changed,
                            out_result.new_state, out_result.out_vertex};

endmodule
